// ===== sv/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== sv/hss_pkg.sv =====
`timescale 1ns / 1ps

package hss_pkg;

  localparam int DATA_W     = 32;
  localparam int HEAT_W     = 48;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = CFG_W'(64);
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] GRID_MIN          = CFG_W'(2);
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT      = CFG_W'(2046);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  localparam logic signed [HEAT_W-1:0] HEAT_MAX = {1'b0, {(HEAT_W-1){1'b1}}};
  localparam logic signed [HEAT_W-1:0] HEAT_MIN = {1'b1, {(HEAT_W-1){1'b0}}};

endpackage

// ===== sv/heat_stencil_sweep.sv =====
`timescale 1ns / 1ps
// jacobi 5-point sweep over a raster stream of the grid with its halo ring.
// throughput: one sample per cycle while in_stall is low; line buffers have one write and one or two reads per cycle.
// results: a result goes out on out_valid once the sample one row below it is transferred; it passes
//   stage a (memory read, stencil add), stage b and the output register (heat accumulate).
// reset: synchronous; counters, heat sum and pipeline valids clear, sizes return to 64x64.
//   line buffers are not cleared; rows 0 and 1 of each sweep fill them before use.
`include "assert_macros.svh"

module heat_stencil_sweep
  import hss_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_W-1:0]     sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_W-1:0]     new_value,
  output logic signed [HEAT_W-1:0]     heat_sum,
  output logic                         sweep_last
);

  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int CW         = $clog2(LINE_DEPTH);

  // line buffers
  logic signed [DATA_W-1:0] line_above  [LINE_DEPTH];
  logic signed [DATA_W-1:0] line_middle [LINE_DEPTH];

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [CW-1:0]    w_eff;
  logic [CW-1:0]    w_last;
  logic [CFG_W-1:0] h_eff;
  logic [CFG_W-1:0] h_last;

  logic [CW-1:0]    col_count;
  logic [CFG_W-1:0] row_count;
  logic [CW-1:0]    rd_col_n;

  logic in_accept;
  logic cfg_write;

  // stage a: memory data registered
  logic                     va;
  logic signed [DATA_W-1:0] s_a;
  logic                     res_a;
  logic                     last_a;
  logic                     end_a;
  logic [CW-1:0]            wr_col_a;
  logic signed [DATA_W-1:0] above_q;
  logic signed [DATA_W-1:0] mid_c_q;
  logic signed [DATA_W-1:0] mid_n_q;
  logic signed [DATA_W-1:0] west;
  logic signed [DATA_W+1:0] sum4;
  logic signed [DATA_W-1:0] nv_a;

  // stage b: new value registered
  logic                     vb;
  logic signed [DATA_W-1:0] nv_b;
  logic                     res_b;
  logic                     last_b;
  logic                     end_b;
  logic signed [HEAT_W-1:0] heat_accum;
  logic signed [HEAT_W:0]   heat_wide;
  logic signed [HEAT_W-1:0] heat_next;

  logic out_free;
  logic b_go;
  logic b_free;
  logic a_go;
  logic a_free;

  // size clamping
  always_comb begin
    if (grid_width < GRID_MIN) begin
      w_eff = CW'(2);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(grid_width);
    end
    if (grid_height < GRID_MIN) begin
      h_eff = GRID_MIN;
    end else if (grid_height > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = grid_height;
    end
  end

  assign w_last = w_eff + CW'(1);
  assign h_last = h_eff + CFG_W'(1);

  // handshake chain
  assign out_free  = !out_valid || !out_stall;
  assign b_go      = vb && (!res_b || out_free);
  assign b_free    = !vb || b_go;
  assign a_go      = va && b_free;
  assign a_free    = !va || a_go;
  assign in_stall  = !a_free;
  assign in_accept = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position of the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_write && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT)) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (col_count == w_last) begin
        col_count <= '0;
        if (row_count >= h_last) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + CFG_W'(1);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // east read address; at the right halo the value is unused
  assign rd_col_n = (col_count == w_last) ? '0 : col_count + CW'(1);

  // line buffer reads, registered on each accepted sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      above_q <= line_above[col_count];
      mid_c_q <= line_middle[col_count];
      mid_n_q <= line_middle[rd_col_n];
    end
  end

  // line buffer writes, issued from stage a (never the address read in the same cycle)
  always_ff @(posedge clk) begin
    if (a_go) begin
      line_above[wr_col_a]  <= mid_c_q;
      line_middle[wr_col_a] <= s_a;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (a_free) begin
      va <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_a      <= sample;
      wr_col_a <= col_count;
      res_a    <= (row_count >= CFG_W'(2)) && (col_count != '0) && (col_count != w_last);
      last_a   <= (row_count == h_last) && (col_count == w_eff);
      end_a    <= (row_count == h_last) && (col_count == w_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      west <= '0;
    end else if (a_go) begin
      west <= mid_c_q;
    end
  end

  assign sum4 = (DATA_W+2)'(above_q) + (DATA_W+2)'(s_a) + (DATA_W+2)'(mid_n_q)
              + (DATA_W+2)'(west);
  assign nv_a = DATA_W'(mid_c_q >>> 1) + DATA_W'(sum4 >>> 3);

  // stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (b_free) begin
      vb <= a_go;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      nv_b   <= nv_a;
      res_b  <= res_a;
      last_b <= last_a;
      end_b  <= end_a;
    end
  end

  // saturating heat sum
  assign heat_wide = (HEAT_W+1)'(heat_accum) + (HEAT_W+1)'(nv_b);
  always_comb begin
    if (heat_wide[HEAT_W] != heat_wide[HEAT_W-1]) begin
      heat_next = heat_wide[HEAT_W] ? HEAT_MIN : HEAT_MAX;
    end else begin
      heat_next = heat_wide[HEAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_accum <= '0;
    end else if (cfg_write && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT)) begin
      heat_accum <= '0;
    end else if (b_go) begin
      if (end_b) begin
        heat_accum <= '0;
      end else if (res_b) begin
        heat_accum <= heat_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= b_go && res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && res_b) begin
      new_value  <= nv_b;
      heat_sum   <= heat_next;
      sweep_last <= last_b;
    end
  end

  `ASSERT_IMPLIES(a_no_rw_clash, clk, rst, a_go && in_accept,
                  wr_col_a != col_count && wr_col_a != rd_col_n)
  `ASSERT_NEXT(a_heat_cleared_at_end, clk, rst, b_go && end_b, heat_accum == '0)
  `ASSERT_NEXT(a_accept_fills_stage, clk, rst, in_accept, va)

endmodule

// ===== tb/heat_stencil_checker.sv =====
`timescale 1ns / 1ps

module heat_stencil_checker
  import hss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [HEAT_W-1:0] heat_sum,
  input  logic                     sweep_last,
  output int                       fail_count,
  output int                       pending
);

  localparam int     LINE_COLS   = MAX_WIDTH_DEFAULT + 2;
  localparam longint HEAT_TOP    = longint'(HEAT_MAX);
  localparam longint HEAT_BOTTOM = longint'(HEAT_MIN);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [HEAT_W-1:0] heat;
    logic                     last;
  } point_result_t;

  logic signed [DATA_W-1:0] line_up  [0:LINE_COLS-1];
  logic signed [DATA_W-1:0] line_mid [0:LINE_COLS-1];
  logic signed [DATA_W-1:0] west_tap = '0;
  logic [CFG_W-1:0]         width_reg  = GRID_WIDTH_RESET;
  logic [CFG_W-1:0]         height_reg = GRID_HEIGHT_RESET;
  int                       col_pos = 0;
  int                       row_pos = 0;
  longint                   heat_run = 0;
  int                       errors = 0;
  point_result_t            point_fifo[$];

  initial begin
    for (int i = 0; i < LINE_COLS; i++) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
  end

  task automatic restart_sweep();
    col_pos  = 0;
    row_pos  = 0;
    heat_run = 0;
  endtask

  always @(posedge clk) begin : watch
    int            w;
    int            h;
    longint        north;
    longint        centre;
    longint        east;
    longint        nv;
    point_result_t due;

    if (rst) begin
      width_reg  = GRID_WIDTH_RESET;
      height_reg = GRID_HEIGHT_RESET;
      restart_sweep();
      point_fifo.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (point_fifo.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: new_value %0d heat_sum %0d sweep_last %0b",
                     new_value, heat_sum, sweep_last);
        end else begin
          due = point_fifo.pop_front();
          if (new_value !== due.value || heat_sum !== due.heat ||
              sweep_last !== due.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: new_value %0d/%0d heat_sum %0d/%0d sweep_last %0b/%0b",
                       due.value, new_value, due.heat, heat_sum, due.last, sweep_last);
          end
        end
      end

      if (in_valid && !in_stall) begin
        w = int'(width_reg);
        h = int'(height_reg);
        if (w < int'(GRID_MIN)) w = int'(GRID_MIN);
        if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
        if (h < int'(GRID_MIN)) h = int'(GRID_MIN);
        if (h > int'(HEIGHT_LIMIT)) h = int'(HEIGHT_LIMIT);

        north  = longint'(line_up[col_pos]);
        centre = longint'(line_mid[col_pos]);
        east   = (col_pos + 1 < LINE_COLS) ? longint'(line_mid[col_pos + 1]) : longint'(0);

        // the row just arriving is the south neighbor of the middle row
        if (row_pos >= 2 && col_pos >= 1 && col_pos <= w) begin
          nv = (centre >>> 1) + ((north + longint'(sample) + east + longint'(west_tap)) >>> 3);
          heat_run = heat_run + nv;
          if (heat_run > HEAT_TOP) heat_run = HEAT_TOP;
          if (heat_run < HEAT_BOTTOM) heat_run = HEAT_BOTTOM;
          due.value = nv[DATA_W-1:0];
          due.heat  = heat_run[HEAT_W-1:0];
          due.last  = (row_pos == h + 1) && (col_pos == w);
          point_fifo.push_back(due);
        end

        west_tap          = centre[DATA_W-1:0];
        line_up[col_pos]  = centre[DATA_W-1:0];
        line_mid[col_pos] = sample;

        if (col_pos >= w + 1) begin
          col_pos = 0;
          if (row_pos >= h + 1) begin
            row_pos  = 0;
            heat_run = 0;
          end else begin
            row_pos++;
          end
        end else begin
          col_pos++;
        end
      end

      // a size write restarts the sweep, line contents stay
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) begin
          width_reg = cfg_data[CFG_W-1:0];
          restart_sweep();
        end else if (cfg_index == REG_GRID_HEIGHT) begin
          height_reg = cfg_data[CFG_W-1:0];
          restart_sweep();
        end
      end
    end

    fail_count <= errors;
    pending    <= point_fifo.size();
  end

endmodule

// ===== tb/tb_heat_stencil_sweep.sv =====
`timescale 1ns / 1ps

module tb_heat_stencil_sweep;
  import hss_pkg::*;

  localparam int CYCLE_LIMIT   = 20_000_000;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int QUIET_ITEMS   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int ODDS_MENU [3] = '{0, 4, 24};

  typedef enum int {FILL_MIXED, FILL_HOT, FILL_COLD} fill_kind_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] new_value;
  logic signed [HEAT_W-1:0] heat_sum;
  logic                     sweep_last;
  int                       fail_count;
  int                       pending;

  int send_odds = 0;
  int recv_odds = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int cycles    = 0;
  int fed       = 0;
  int cur_w     = 64;
  int cur_h     = 64;

  always #5 clk = ~clk;

  heat_stencil_sweep u_top (.*);

  heat_stencil_checker u_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_heat_stencil_sweep NOT OK");
      $finish;
    end
  end

  function automatic int clamp_size(input int v, input int hi);
    if (v < int'(GRID_MIN)) return int'(GRID_MIN);
    if (v > hi) return hi;
    return v;
  endfunction

  // size in the low bits, junk above them
  function automatic logic [CFG_DATA_W-1:0] size_word(input int v);
    return {21'($urandom), 11'(v)};
  endfunction

  task automatic feed(input int count, input fill_kind_t kind);
    logic signed [DATA_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      case (kind)
        FILL_HOT:  v = 32'h7FFF_FFFF - $urandom_range(0, 255);
        FILL_COLD: v = {1'b1, 31'($urandom_range(0, 255))};
        default: begin
          case ($urandom_range(0, 7))
            0:       v = {1'b1, {(DATA_W-1){1'b0}}};
            1:       v = {1'b0, {(DATA_W-1){1'b1}}};
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom;
          endcase
        end
      endcase
      if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_valid <= 1'b1;
      sample   <= v;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      fed++;
    end
  endtask

  // drop valid and let the block drain, including items with no result
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_WIDTH)
      cur_w = clamp_size(int'(data[CFG_W-1:0]), MAX_WIDTH_DEFAULT);
    else if (idx == REG_GRID_HEIGHT)
      cur_h = clamp_size(int'(data[CFG_W-1:0]), int'(HEIGHT_LIMIT));
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // long hold-off so the block backs up into its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int n;
    int w;
    int h;
    int random_start;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset size, three rows and a bit while the receiver holds off
    send_odds = 4;
    recv_odds = 8;
    hold_req  = 1'b1;
    feed((cur_w + 2) * 3 + 5, FILL_MIXED);

    // sizes below the minimum, two sweeps back to back
    write_reg(REG_GRID_WIDTH, size_word(0));
    write_reg(REG_GRID_HEIGHT, size_word(1));
    feed(32, FILL_MIXED);

    // write to a missing register in the middle of a sweep changes nothing
    feed(6, FILL_MIXED);
    write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
    feed(10, FILL_MIXED);

    // a real write in the middle of a sweep restarts it
    feed(7, FILL_MIXED);
    write_reg(REG_GRID_HEIGHT, size_word(3));
    feed((cur_w + 2) * (cur_h + 2), FILL_MIXED);

    // sizes beyond their limits, the start of a sweep only
    send_odds = 24;
    recv_odds = 24;
    write_reg(REG_GRID_WIDTH, size_word(2047));
    write_reg(REG_GRID_HEIGHT, size_word(2047));
    feed(40, FILL_MIXED);

    // hot samples near the positive limit
    write_reg(REG_GRID_WIDTH, size_word(33));
    write_reg(REG_GRID_HEIGHT, size_word(4));
    feed((cur_w + 2) * (cur_h + 2), FILL_HOT);

    // cold samples near the negative limit
    write_reg(REG_GRID_WIDTH, size_word(20));
    write_reg(REG_GRID_HEIGHT, size_word(3));
    feed((cur_w + 2) * (cur_h + 2), FILL_COLD);

    random_start = fed;
    while (fed - random_start < RANDOM_ITEMS) begin
      if (fed - random_start > RANDOM_ITEMS - QUIET_ITEMS) begin
        send_odds = 0;
        recv_odds = 0;
      end else begin
        send_odds = ODDS_MENU[$urandom_range(0, 2)];
        recv_odds = ODDS_MENU[$urandom_range(0, 2)];
      end
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
      h = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0: write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
        1: write_reg(REG_GRID_WIDTH, size_word(w));
        9: ;  // carry on from wherever the last transfer left the sweep
        default: begin
          write_reg(REG_GRID_WIDTH, size_word(w));
          write_reg(REG_GRID_HEIGHT, size_word(h));
        end
      endcase
      n = (cur_w + 2) * (cur_h + 2);
      if ($urandom_range(0, 4) == 0)
        n = $urandom_range(1, n - 1);
      else
        n = n * $urandom_range(1, 2);
      feed(n, FILL_MIXED);
    end

    send_odds = 0;
    recv_odds = 0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_heat_stencil_sweep OK");
    else
      $display("tb_heat_stencil_sweep NOT OK");
    $finish;
  end

endmodule
